// ----- rtl/core/bcc_pkg.sv -----
// Shared constants, command codes and types of the coulomb counter.
package bcc_pkg;

    // default fixed-point and counter widths
    localparam int FRACTION_BITS = 8;
    localparam int COUNTER_WIDTH = 48;

    // field widths
    localparam int CUR_W    = 16;
    localparam int MODE_W   = 3;
    localparam int TIME_W   = 32;
    localparam int CHARGE_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;
    localparam int LOG_FRAC = 16;

    // battery modes
    localparam logic [MODE_W-1:0] MODE_UNKNOWN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHARGE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCV_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEUKERT_K = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CUR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESIST    = 3'd6;

    // datapath commands
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] CMD_NOP        = 5'd0;
    localparam logic [OP_W-1:0] CMD_LATCH      = 5'd1;
    localparam logic [OP_W-1:0] CMD_CLASS      = 5'd2;
    localparam logic [OP_W-1:0] CMD_LOG_INIT_A = 5'd3;
    localparam logic [OP_W-1:0] CMD_LOG_INIT_B = 5'd4;
    localparam logic [OP_W-1:0] CMD_LOG_STEP   = 5'd5;
    localparam logic [OP_W-1:0] CMD_LOG_END_A  = 5'd6;
    localparam logic [OP_W-1:0] CMD_LOG_END_B  = 5'd7;
    localparam logic [OP_W-1:0] CMD_EXPO       = 5'd8;
    localparam logic [OP_W-1:0] CMD_EXP_STEP   = 5'd9;
    localparam logic [OP_W-1:0] CMD_MAG        = 5'd10;
    localparam logic [OP_W-1:0] CMD_SHIFT      = 5'd11;
    localparam logic [OP_W-1:0] CMD_DIV_STEP   = 5'd12;
    localparam logic [OP_W-1:0] CMD_GAIN       = 5'd13;
    localparam logic [OP_W-1:0] CMD_PMUL       = 5'd14;
    localparam logic [OP_W-1:0] CMD_CHG_TOT    = 5'd15;
    localparam logic [OP_W-1:0] CMD_WHOLE      = 5'd16;
    localparam logic [OP_W-1:0] CMD_DELTA      = 5'd17;
    localparam logic [OP_W-1:0] CMD_ACCUM      = 5'd18;
    localparam logic [OP_W-1:0] CMD_EMIT       = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [3:0]      step;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [MODE_W-1:0] mode_new;
    } status_t;

    // Q30 factors 2^(2^-j), j = 1..16, stored at j-1
    typedef logic [30:0] root_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic root_tab_t root_table();
        root_tab_t   t;
        logic [63:0] f;
        f = 64'd2 << 30;
        for (int j = 0; j < 16; j++) begin
            f    = isqrt64(f << 30);
            t[j] = f[30:0];
        end
        return t;
    endfunction

endpackage

// ----- rtl/core/bcc_ctrl.sv -----
// Sequencer that steps the coulomb counter datapath through one word.
module bcc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  bcc_pkg::status_t status,
    output bcc_pkg::cmd_t    cmd
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_CLASS    = 5'd1;
    localparam logic [4:0] ST_LA_INIT  = 5'd2;
    localparam logic [4:0] ST_LA_STEP  = 5'd3;
    localparam logic [4:0] ST_LA_END   = 5'd4;
    localparam logic [4:0] ST_LB_INIT  = 5'd5;
    localparam logic [4:0] ST_LB_STEP  = 5'd6;
    localparam logic [4:0] ST_LB_END   = 5'd7;
    localparam logic [4:0] ST_EXPO     = 5'd8;
    localparam logic [4:0] ST_EXP_STEP = 5'd9;
    localparam logic [4:0] ST_MAG      = 5'd10;
    localparam logic [4:0] ST_SHIFT    = 5'd11;
    localparam logic [4:0] ST_DIV_STEP = 5'd12;
    localparam logic [4:0] ST_GAIN     = 5'd13;
    localparam logic [4:0] ST_PMUL     = 5'd14;
    localparam logic [4:0] ST_CHG_TOT  = 5'd15;
    localparam logic [4:0] ST_WHOLE    = 5'd16;
    localparam logic [4:0] ST_DELTA    = 5'd17;
    localparam logic [4:0] ST_ACCUM    = 5'd18;
    localparam logic [4:0] ST_DONE     = 5'd19;

    localparam logic [4:0] LAST_SQ  = 5'd15;
    localparam logic [4:0] LAST_DIV = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    // sequence the steps of one word
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = m_ready ? 1'b0 : mvalid_reg;
        cmd.op      = bcc_pkg::CMD_NOP;
        cmd.step    = cnt_reg[3:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = bcc_pkg::CMD_LATCH;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                cmd.op   = bcc_pkg::CMD_CLASS;
                cnt_next = 5'd0;
                priority if (status.kind) begin
                    state_next = ST_DONE;
                end else if (status.mode_new == bcc_pkg::MODE_DISCHARGE) begin
                    state_next = ST_LA_INIT;
                end else if (status.mode_new == bcc_pkg::MODE_CHARGE) begin
                    state_next = ST_DIV_STEP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LA_INIT: begin
                cmd.op     = bcc_pkg::CMD_LOG_INIT_A;
                cnt_next   = 5'd0;
                state_next = ST_LA_STEP;
            end
            ST_LA_STEP: begin
                cmd.op = bcc_pkg::CMD_LOG_STEP;
                if (cnt_reg == LAST_SQ) begin
                    state_next = ST_LA_END;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_LA_END: begin
                cmd.op     = bcc_pkg::CMD_LOG_END_A;
                state_next = ST_LB_INIT;
            end
            ST_LB_INIT: begin
                cmd.op     = bcc_pkg::CMD_LOG_INIT_B;
                cnt_next   = 5'd0;
                state_next = ST_LB_STEP;
            end
            ST_LB_STEP: begin
                cmd.op = bcc_pkg::CMD_LOG_STEP;
                if (cnt_reg == LAST_SQ) begin
                    state_next = ST_LB_END;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_LB_END: begin
                cmd.op     = bcc_pkg::CMD_LOG_END_B;
                state_next = ST_EXPO;
            end
            ST_EXPO: begin
                cmd.op     = bcc_pkg::CMD_EXPO;
                cnt_next   = 5'd0;
                state_next = ST_EXP_STEP;
            end
            ST_EXP_STEP: begin
                cmd.op = bcc_pkg::CMD_EXP_STEP;
                if (cnt_reg == LAST_SQ) begin
                    state_next = ST_MAG;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_MAG: begin
                cmd.op     = bcc_pkg::CMD_MAG;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.op     = bcc_pkg::CMD_SHIFT;
                state_next = ST_WHOLE;
            end
            ST_DIV_STEP: begin
                cmd.op = bcc_pkg::CMD_DIV_STEP;
                if (cnt_reg == LAST_DIV) begin
                    state_next = ST_GAIN;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_GAIN: begin
                cmd.op     = bcc_pkg::CMD_GAIN;
                state_next = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.op     = bcc_pkg::CMD_PMUL;
                state_next = ST_CHG_TOT;
            end
            ST_CHG_TOT: begin
                cmd.op     = bcc_pkg::CMD_CHG_TOT;
                state_next = ST_WHOLE;
            end
            ST_WHOLE: begin
                cmd.op     = bcc_pkg::CMD_WHOLE;
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                cmd.op     = bcc_pkg::CMD_DELTA;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.op     = bcc_pkg::CMD_ACCUM;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!mvalid_reg || m_ready) begin
                    cmd.op      = bcc_pkg::CMD_EMIT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 5'd0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ----- rtl/core/bcc_dp.sv -----
// Datapath of the coulomb counter: settings, counter state and arithmetic steps.
module bcc_dp #(
    parameter int FRACTION_BITS = bcc_pkg::FRACTION_BITS,
    parameter int COUNTER_WIDTH = bcc_pkg::COUNTER_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 in_kind,
    input  logic signed [bcc_pkg::CUR_W-1:0]     in_current_ma,
    input  bcc_pkg::cmd_t                        cmd,
    output bcc_pkg::status_t                     status,
    output logic [bcc_pkg::MODE_W-1:0]           out_battery_mode,
    output logic [bcc_pkg::TIME_W-1:0]           out_time_in_mode,
    output logic signed [bcc_pkg::CHARGE_W-1:0]  out_releasable_charge,
    output logic                                 out_saturated
);

    localparam int FB = FRACTION_BITS;
    localparam int CW = COUNTER_WIDTH;
    localparam logic signed [65:0] CNT_HI = 66'((66'sd1 <<< (CW - 1)) - 66'sd1);
    localparam logic signed [65:0] CNT_LO = -CNT_HI - 66'sd1;
    localparam bcc_pkg::root_tab_t ROOT = bcc_pkg::root_table();
    localparam logic [30:0] Q30_ONE = 31'd1 << 30;
    localparam logic [17:0] SOC_FULL = 18'd2 << bcc_pkg::LOG_FRAC;

    // settings
    logic [14:0] thr_reg;
    logic [15:0] wait_reg;
    logic [11:0] intv_reg;
    logic [46:0] maxc_reg;
    logic [14:0] kexp_reg;
    logic [15:0] base_reg;
    logic [15:0] rres_reg;

    // counter state
    logic [2:0]             mode_reg, mode_next;
    logic [31:0]            time_reg, time_next;
    logic signed [CW-1:0]   cc_reg, cc_next;
    logic signed [FB:0]     rem_reg, rem_next;
    logic                   sat_reg, sat_next;

    // word under work
    logic                   kind_reg, kind_next;
    logic signed [15:0]     cur_reg, cur_next;
    logic [30:0]            lm_reg, lm_next;
    logic [3:0]             lp_reg, lp_next;
    logic [15:0]            lf_reg, lf_next;
    logic signed [20:0]     lg_reg, lg_next;
    logic signed [5:0]      q_reg, q_next;
    logic [15:0]            r_reg, r_next;
    logic [30:0]            em_reg, em_next;
    logic [46:0]            mag_reg, mag_next;
    logic signed [63:0]     tot_reg, tot_next;
    logic [47:0]            dr_reg, dr_next;
    logic [16:0]            dq_reg, dq_next;
    logic [33:0]            rg_reg, rg_next;
    logic [49:0]            p_reg, p_next;
    logic signed [63:0]     whole_reg, whole_next;
    logic signed [63:0]     delta_reg, delta_next;

    // output register
    logic [2:0]             omode_reg;
    logic [31:0]            otime_reg;
    logic [47:0]            ocharge_reg;
    logic                   osat_reg;

    // helper terms
    logic [15:0]        abs_cur;
    logic signed [16:0] cur17, thr17;
    logic signed [17:0] band_sum;
    logic [2:0]         cls_mode;
    logic [32:0]        time_sum;
    logic [15:0]        log_src, log_n;
    logic [3:0]         log_p;
    logic [61:0]        sq;
    logic [13:0]        e_val;
    logic signed [35:0] prod_d;
    logic signed [21:0] d_val;
    logic [61:0]        exp_prod;
    logic signed [7:0]  ssh, nsh;
    logic [63:0]        shifted;
    logic signed [63:0] rem_ext;
    logic signed [63:0] peuk_tot;
    logic [46:0]        maxc_eff;
    logic [47:0]        maxc48;
    logic               div_ge;
    logic [47:0]        div_t;
    logic signed [63:0] cc64;
    logic               cc_pos, cc_full;
    logic [17:0]        soc, gain;
    logic [49:0]        psh;
    logic signed [63:0] chg_t, chg_tot;
    logic [63:0]        tot_mag, whole_mag;
    logic signed [63:0] whole_val, rem_full;
    logic signed [45:0] delta_prod;
    logic signed [65:0] acc_sum;
    logic signed [65:0] maxc66;

    assign abs_cur = cur_reg[15] ? 16'(-cur_reg) : cur_reg;

    // classify the sample
    assign cur17    = 17'(cur_reg);
    assign thr17    = $signed({2'b00, thr_reg});
    assign band_sum = 18'(cur17) + 18'(thr17);
    always_comb begin
        priority if (cur17 > thr17) begin
            cls_mode = bcc_pkg::MODE_CHARGE;
        end else if (band_sum[17]) begin
            cls_mode = bcc_pkg::MODE_DISCHARGE;
        end else if (time_reg < {16'd0, wait_reg}) begin
            cls_mode = bcc_pkg::MODE_WAIT;
        end else begin
            cls_mode = bcc_pkg::MODE_IDLE;
        end
    end
    assign time_sum = {1'b0, time_reg} + 33'(intv_reg);

    assign status.kind     = kind_reg;
    assign status.mode_new = cls_mode;

    // log2 normalization
    assign log_src = (cmd.op == bcc_pkg::CMD_LOG_INIT_B) ? base_reg : abs_cur;
    assign log_n   = (log_src == 16'd0) ? 16'd1 : log_src;
    always_comb begin
        log_p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (log_n[i]) begin
                log_p = 4'(i);
            end
        end
    end
    assign sq = 62'(lm_reg) * 62'(lm_reg);

    // exponent scaling and fractional power
    assign e_val    = (kexp_reg > 15'd16384) ? 14'(kexp_reg - 15'd16384) : 14'd0;
    assign prod_d   = 36'(lg_reg) * $signed({22'd0, e_val});
    assign d_val    = 22'(prod_d >>> 14);
    assign exp_prod = 62'(em_reg) * 62'(ROOT[cmd.step]);

    // scale the Peukert magnitude
    assign ssh = $signed({{2{q_reg[5]}}, q_reg}) + 8'(FB) - 8'sd30;
    assign nsh = -ssh;
    always_comb begin
        if (!ssh[7]) begin
            shifted = {17'd0, mag_reg} << ssh[5:0];
        end else if (nsh >= 8'sd64) begin
            shifted = 64'd0;
        end else begin
            shifted = {17'd0, mag_reg} >> nsh[5:0];
        end
    end
    assign rem_ext  = 64'(rem_reg);
    assign peuk_tot = (cur_reg[15] ? -$signed(shifted) : $signed(shifted)) + rem_ext;

    // state of charge division and charge correction
    assign maxc_eff = (maxc_reg == 47'd0) ? 47'd1 : maxc_reg;
    assign maxc48   = {1'b0, maxc_eff};
    assign div_ge   = dr_reg >= maxc48;
    assign div_t    = div_ge ? dr_reg - maxc48 : dr_reg;
    assign cc64     = 64'(cc_reg);
    assign cc_pos   = !cc_reg[CW-1] && (cc_reg != '0);
    assign cc_full  = {1'b0, cc64} >= {17'd0, maxc_eff, 1'b0};
    always_comb begin
        priority if (!cc_pos) begin
            soc = 18'd0;
        end else if (cc_full) begin
            soc = SOC_FULL;
        end else begin
            soc = {1'b0, dq_reg};
        end
    end
    assign gain    = SOC_FULL - soc;
    assign psh     = p_reg >> (32 - FB);
    assign chg_t   = $signed(64'(abs_cur) << FB) - $signed(64'(psh));
    assign chg_tot = (cur_reg[15] ? -chg_t : chg_t) + rem_ext;

    // split whole mA from the carried fraction
    assign tot_mag   = tot_reg[63] ? 64'(-tot_reg) : 64'(tot_reg);
    assign whole_mag = tot_mag >> FB;
    assign whole_val = tot_reg[63] ? -$signed(whole_mag) : $signed(whole_mag);
    assign rem_full  = tot_reg - (whole_val <<< FB);

    // whole mA stays below 2^31 in magnitude, so a 33 x 13 product is enough
    assign delta_prod = $signed(whole_reg[32:0]) * $signed({1'b0, intv_reg});

    assign acc_sum = 66'(cc_reg) + 66'(delta_reg);
    assign maxc66  = $signed({19'd0, maxc_reg});

    // step the datapath
    always_comb begin
        mode_next  = mode_reg;
        time_next  = time_reg;
        cc_next    = cc_reg;
        rem_next   = rem_reg;
        sat_next   = sat_reg;
        kind_next  = kind_reg;
        cur_next   = cur_reg;
        lm_next    = lm_reg;
        lp_next    = lp_reg;
        lf_next    = lf_reg;
        lg_next    = lg_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        em_next    = em_reg;
        mag_next   = mag_reg;
        tot_next   = tot_reg;
        dr_next    = dr_reg;
        dq_next    = dq_reg;
        rg_next    = rg_reg;
        p_next     = p_reg;
        whole_next = whole_reg;
        delta_next = delta_reg;
        unique case (cmd.op)
            bcc_pkg::CMD_LATCH: begin
                kind_next = in_kind;
                cur_next  = in_current_ma;
            end
            bcc_pkg::CMD_CLASS: begin
                dr_next = cc64[47:0];
                dq_next = 17'd0;
                if (kind_reg) begin
                    if (maxc66 > CNT_HI) begin
                        cc_next  = CW'(CNT_HI);
                        sat_next = 1'b1;
                    end else begin
                        cc_next  = CW'(maxc66);
                        sat_next = 1'b0;
                    end
                end else begin
                    sat_next = 1'b0;
                    if (cls_mode == mode_reg) begin
                        time_next = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
                    end else begin
                        mode_next = cls_mode;
                        time_next = 32'd0;
                    end
                end
            end
            bcc_pkg::CMD_LOG_INIT_A, bcc_pkg::CMD_LOG_INIT_B: begin
                lm_next = 31'({15'd0, log_n} << (5'd30 - {1'b0, log_p}));
                lp_next = log_p;
                lf_next = 16'd0;
            end
            bcc_pkg::CMD_LOG_STEP: begin
                if (sq[61]) begin
                    lm_next             = sq[61:31];
                    lf_next[~cmd.step]  = 1'b1;
                end else begin
                    lm_next = sq[60:30];
                end
            end
            bcc_pkg::CMD_LOG_END_A: begin
                lg_next = $signed({1'b0, lp_reg, lf_reg});
            end
            bcc_pkg::CMD_LOG_END_B: begin
                lg_next = lg_reg - $signed({1'b0, lp_reg, lf_reg});
            end
            bcc_pkg::CMD_EXPO: begin
                q_next  = 6'(d_val >>> 16);
                r_next  = d_val[15:0];
                em_next = Q30_ONE;
            end
            bcc_pkg::CMD_EXP_STEP: begin
                if (r_reg[~cmd.step]) begin
                    em_next = exp_prod[60:30];
                end
            end
            bcc_pkg::CMD_MAG: begin
                mag_next = 47'(abs_cur) * 47'(em_reg);
            end
            bcc_pkg::CMD_SHIFT: begin
                tot_next = peuk_tot;
            end
            bcc_pkg::CMD_DIV_STEP: begin
                dq_next = {dq_reg[15:0], div_ge};
                dr_next = {div_t[46:0], 1'b0};
            end
            bcc_pkg::CMD_GAIN: begin
                rg_next = 34'(rres_reg) * 34'(gain);
            end
            bcc_pkg::CMD_PMUL: begin
                p_next = 50'(abs_cur) * 50'(rg_reg);
            end
            bcc_pkg::CMD_CHG_TOT: begin
                tot_next = chg_tot;
            end
            bcc_pkg::CMD_WHOLE: begin
                whole_next = whole_val;
                rem_next   = rem_full[FB:0];
            end
            bcc_pkg::CMD_DELTA: begin
                delta_next = 64'(delta_prod);
            end
            bcc_pkg::CMD_ACCUM: begin
                priority if (acc_sum > CNT_HI) begin
                    cc_next  = CW'(CNT_HI);
                    sat_next = 1'b1;
                end else if (acc_sum < CNT_LO) begin
                    cc_next  = CW'(CNT_LO);
                    sat_next = 1'b1;
                end else begin
                    cc_next = acc_sum[CW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // settings writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= 15'd0;
            wait_reg <= 16'd0;
            intv_reg <= 12'd1;
            maxc_reg <= 47'd1;
            kexp_reg <= 15'd16384;
            base_reg <= 16'd1;
            rres_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bcc_pkg::REG_THRESHOLD: thr_reg  <= cfg_wdata[14:0];
                bcc_pkg::REG_OCV_WAIT:  wait_reg <= cfg_wdata[15:0];
                bcc_pkg::REG_INTERVAL:  intv_reg <= cfg_wdata[11:0];
                bcc_pkg::REG_MAX_CAP:   maxc_reg <= cfg_wdata[46:0];
                bcc_pkg::REG_PEUKERT_K: kexp_reg <= cfg_wdata[14:0];
                bcc_pkg::REG_BASE_CUR:  base_reg <= cfg_wdata[15:0];
                bcc_pkg::REG_RESIST:    rres_reg <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= bcc_pkg::MODE_UNKNOWN;
            time_reg <= 32'd0;
            cc_reg   <= '0;
            rem_reg  <= '0;
            sat_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            time_reg <= time_next;
            cc_reg   <= cc_next;
            rem_reg  <= rem_next;
            sat_reg  <= sat_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        cur_reg   <= cur_next;
        lm_reg    <= lm_next;
        lp_reg    <= lp_next;
        lf_reg    <= lf_next;
        lg_reg    <= lg_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        em_reg    <= em_next;
        mag_reg   <= mag_next;
        tot_reg   <= tot_next;
        dr_reg    <= dr_next;
        dq_reg    <= dq_next;
        rg_reg    <= rg_next;
        p_reg     <= p_next;
        whole_reg <= whole_next;
        delta_reg <= delta_next;
    end

    // load the result word
    always_ff @(posedge aclk) begin
        if (cmd.op == bcc_pkg::CMD_EMIT) begin
            omode_reg   <= mode_reg;
            otime_reg   <= time_reg;
            ocharge_reg <= cc64[47:0];
            osat_reg    <= sat_reg;
        end
    end

    assign out_battery_mode      = omode_reg;
    assign out_time_in_mode      = otime_reg;
    assign out_releasable_charge = $signed(ocharge_reg);
    assign out_saturated         = osat_reg;

endmodule

// ----- rtl/core/battery_coulomb_counter.sv -----
// Top level of the battery coulomb counter with Peukert and resistance correction.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_kind s_current_ma      | in
//  m_      | m_valid m_ready m_battery_mode ...       | out
//  cfg_    | cfg_wr_en cfg_index cfg_wdata            | in
//
// One word at a time. A restart word or a wait or idle sample goes from
// classification straight to the result; a charge sample runs a 17-bit
// bit-serial state-of-charge division, a discharge sample two 16-step log2
// squaring loops and a 16-step power loop on 31x31 multipliers.
// Reset is synchronous, active low; it clears settings to defaults and the counter.
// A result stalled on m_ready holds the next word in its last cycle.
module battery_coulomb_counter #(
    parameter int FRACTION_BITS = bcc_pkg::FRACTION_BITS,
    parameter int COUNTER_WIDTH = bcc_pkg::COUNTER_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [bcc_pkg::CUR_W-1:0]     s_current_ma,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bcc_pkg::MODE_W-1:0]           m_battery_mode,
    output logic [bcc_pkg::TIME_W-1:0]           m_time_in_mode,
    output logic signed [bcc_pkg::CHARGE_W-1:0]  m_releasable_charge,
    output logic                                 m_saturated
);

    localparam logic [63:0] CNT_HI = 64'((65'd1 << (COUNTER_WIDTH - 1)) - 65'd1);
    localparam logic [63:0] CNT_LO = ~CNT_HI;

    bcc_pkg::cmd_t    cmd;
    bcc_pkg::status_t status;

    bcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bcc_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .in_kind               (s_kind),
        .in_current_ma         (s_current_ma),
        .cmd                   (cmd),
        .status                (status),
        .out_battery_mode      (m_battery_mode),
        .out_time_in_mode      (m_time_in_mode),
        .out_releasable_charge (m_releasable_charge),
        .out_saturated         (m_saturated)
    );

    // one word in flight: no second accept right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in work");

    // a clamped counter sits on one of its bounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_releasable_charge == CNT_HI[47:0] || m_releasable_charge == CNT_LO[47:0]))
        else $error("saturated flag without counter at a bound");

    // a new result only appears after a word was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready || $past(!s_ready))
        else $error("result raised without a word in work");

endmodule
